[rtl/core/cdeb_pkg.sv]
// ----------------------------------------------------------------------------
// cdeb_pkg
// Types and codes shared by the directory entry controller, datapath and top.
// ----------------------------------------------------------------------------
package cdeb_pkg;

   // Operation codes carried in the request beat.
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_OWNER  = 2'd2;
   localparam logic [1:0] OP_LIST   = 2'd3;

   // Status codes returned in each response beat.
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_ADD_EXISTING = 3'd1;
   localparam logic [2:0] ST_REMOVE_ABSENT = 3'd2;
   localparam logic [2:0] ST_REPLY_NO_BC  = 3'd3;
   localparam logic [2:0] ST_OWNER_NOT_SH = 3'd4;
   localparam logic [2:0] ST_BITS_LEFT    = 3'd5;

   // Register indexes of the CSR write channel.
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_TILES    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HW_SHARERS = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [6:0] TOTAL_TILES_RESET    = 7'd64;
   localparam logic [6:0] MAX_HW_SHARERS_RESET = 7'd4;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] tile;
      logic       reply_due;
      logic       owner_valid;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] sharer_count;
      logic       broadcast;
      logic [5:0] owner;
      logic       owner_present;
      logic [5:0] listed_tile;
      logic       sharer_valid;
      logic       last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the accepted request beat
      logic update;      // apply a non-list operation and load its response
      logic list_start;  // load the list working copy
      logic list_emit;   // emit one listed sharer into the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_list;     // latched request is a list request
      logic list_last;   // next emitted list beat is the final one
   } dp_stat_type;

endpackage

[rtl/core/cdeb_ctrl.sv]
// ----------------------------------------------------------------------------
// cdeb_ctrl
// Sequencing controller: accepts a request, runs it in the datapath and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module cdeb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cdeb_pkg::cmd_type     cmd,
   input  cdeb_pkg::dp_stat_type stat
);
   import cdeb_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LIST = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic       load;

   // The response register may be reloaded once it is empty or being taken.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               if (stat.is_list) begin
                  cmd.list_start = 1'b1;
                  state_in       = S_LIST;
               end else begin
                  cmd.update = 1'b1;
                  load       = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_LIST: begin
            if (slot_free) begin
               cmd.list_emit = 1'b1;
               load          = 1'b1;
               if (stat.list_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid: set on a load, cleared when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/cdeb_datapath.sv]
// ----------------------------------------------------------------------------
// cdeb_datapath
// Directory entry state, configuration registers, list walker and the
// response register.
// ----------------------------------------------------------------------------
module cdeb_datapath #(
   parameter int TILES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cdeb_pkg::req_type               req_data,
   output cdeb_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   input  logic [cdeb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [6:0]                     csr_data,
   input  cdeb_pkg::cmd_type               cmd,
   output cdeb_pkg::dp_stat_type           stat
);
   import cdeb_pkg::*;

   localparam int IDX_W = (TILES > 1) ? $clog2(TILES) : 1;

   // Configuration registers.
   logic [6:0] total_tiles_ff;
   logic [6:0] max_hw_sharers_ff;

   // Entry state; count_ff tracks the population of sharer_ff.
   logic [TILES-1:0] sharer_ff, sharer_in;
   logic [6:0]       count_ff, count_in;
   logic             bcast_ff, bcast_in;
   logic [6:0]       countdown_ff, countdown_in;
   logic [5:0]       owner_ff, owner_in;
   logic             owner_set_ff, owner_set_in;

   // Latched request, list walker and response payload.
   req_type          req_ff;
   logic [TILES-1:0] work_ff;
   logic [6:0]       list_cnt_ff;
   rsp_type          rsp_ff;

   logic             in_range;
   logic [IDX_W-1:0] tile_idx;
   logic             has_bit;
   logic [TILES-1:0] tile_mask;
   logic [6:0]       eff_total;
   logic [2:0]       status;
   logic [6:0]       dec_cd;
   logic [TILES-1:0] low_bit;
   logic [IDX_W-1:0] low_idx;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_tiles_ff    <= TOTAL_TILES_RESET;
         max_hw_sharers_ff <= MAX_HW_SHARERS_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_TOTAL_TILES) begin
            total_tiles_ff <= csr_data;
         end else if (csr_index == CSR_MAX_HW_SHARERS) begin
            max_hw_sharers_ff <= csr_data;
         end
      end
   end

   // Total tiles clamped into the range one to TILES.
   always_comb begin
      if (total_tiles_ff == 7'd0) begin
         eff_total = 7'd1;
      end else if (total_tiles_ff > 7'(TILES)) begin
         eff_total = 7'(TILES);
      end else begin
         eff_total = total_tiles_ff;
      end
   end

   // Decode of the latched tile.
   assign in_range  = ({1'b0, req_ff.tile} < 7'(TILES));
   assign tile_idx  = req_ff.tile[IDX_W-1:0];
   assign has_bit   = in_range && sharer_ff[tile_idx];
   assign tile_mask = TILES'(1) << tile_idx;
   assign dec_cd    = countdown_ff - 7'd1;

   // Operation logic: a nonzero status leaves the state as it was.
   always_comb begin
      sharer_in    = sharer_ff;
      count_in     = count_ff;
      bcast_in     = bcast_ff;
      countdown_in = countdown_ff;
      owner_in     = owner_ff;
      owner_set_in = owner_set_ff;
      status       = ST_OK;
      case (req_ff.operation)
         OP_ADD: begin
            if (!bcast_ff && in_range) begin
               if (has_bit) begin
                  status = ST_ADD_EXISTING;
               end else if (count_ff >= max_hw_sharers_ff) begin
                  bcast_in     = 1'b1;
                  countdown_in = eff_total;
               end else begin
                  sharer_in = sharer_ff | tile_mask;
                  count_in  = count_ff + 7'd1;
               end
            end
         end
         OP_REMOVE: begin
            if (has_bit) begin
               sharer_in = sharer_ff & ~tile_mask;
               count_in  = count_ff - 7'd1;
            end else if (!bcast_ff) begin
               status = ST_REMOVE_ABSENT;
            end
            if (status == ST_OK && req_ff.reply_due) begin
               if (!bcast_ff) begin
                  status = ST_REPLY_NO_BC;
               end else begin
                  countdown_in = dec_cd;
                  if (dec_cd == 7'd0) begin
                     bcast_in = 1'b0;
                     if (count_in != 7'd0) begin
                        status = ST_BITS_LEFT;
                     end
                  end
               end
            end
            if (status != ST_OK) begin
               sharer_in    = sharer_ff;
               count_in     = count_ff;
               bcast_in     = bcast_ff;
               countdown_in = countdown_ff;
            end
         end
         OP_OWNER: begin
            if (req_ff.owner_valid) begin
               if (has_bit) begin
                  owner_in     = req_ff.tile;
                  owner_set_in = 1'b1;
               end else begin
                  status = ST_OWNER_NOT_SH;
               end
            end else begin
               owner_in     = 6'd0;
               owner_set_in = 1'b0;
            end
         end
         default: begin
            // A list request leaves the entry untouched.
         end
      endcase
   end

   // Lowest remaining sharer of the list working copy and its index.
   assign low_bit = work_ff & (~work_ff + TILES'(1));
   always_comb begin
      low_idx = '0;
      for (int j = 0; j < TILES; j++) begin
         if (low_bit[j]) begin
            low_idx = low_idx | IDX_W'(j);
         end
      end
   end

   // Entry state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sharer_ff    <= '0;
         count_ff     <= 7'd0;
         bcast_ff     <= 1'b0;
         countdown_ff <= 7'd0;
         owner_ff     <= 6'd0;
         owner_set_ff <= 1'b0;
      end else if (cmd.update) begin
         sharer_ff    <= sharer_in;
         count_ff     <= count_in;
         bcast_ff     <= bcast_in;
         countdown_ff <= countdown_in;
         owner_ff     <= owner_in;
         owner_set_ff <= owner_set_in;
      end
   end

   // Request latch, list walker and response payload.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.list_start) begin
         work_ff     <= sharer_ff;
         list_cnt_ff <= count_ff;
      end
      if (cmd.update) begin
         rsp_ff.status        <= status;
         rsp_ff.sharer_count  <= bcast_in ? eff_total : count_in;
         rsp_ff.broadcast     <= bcast_in;
         rsp_ff.owner         <= owner_in;
         rsp_ff.owner_present <= owner_set_in;
         rsp_ff.listed_tile   <= 6'd0;
         rsp_ff.sharer_valid  <= 1'b0;
         rsp_ff.last          <= 1'b1;
      end else if (cmd.list_emit) begin
         rsp_ff.status        <= ST_OK;
         rsp_ff.sharer_count  <= bcast_ff ? eff_total : count_ff;
         rsp_ff.broadcast     <= bcast_ff;
         rsp_ff.owner         <= owner_ff;
         rsp_ff.owner_present <= owner_set_ff;
         if (list_cnt_ff == 7'd0) begin
            rsp_ff.listed_tile  <= 6'd0;
            rsp_ff.sharer_valid <= 1'b0;
            rsp_ff.last         <= 1'b1;
         end else begin
            rsp_ff.listed_tile  <= 6'(low_idx);
            rsp_ff.sharer_valid <= 1'b1;
            rsp_ff.last         <= (list_cnt_ff == 7'd1);
            work_ff             <= work_ff & ~low_bit;
            list_cnt_ff         <= list_cnt_ff - 7'd1;
         end
      end
   end

   assign rsp_data       = rsp_ff;
   assign stat.is_list   = (req_ff.operation == OP_LIST);
   assign stat.list_last = (list_cnt_ff <= 7'd1);

endmodule

[rtl/core/coherence_directory_entry_broadcast.sv]
// An accepted request beat is latched; an update then applies its operation
// and loads its response. A list request loads the list working copy, then
// emits one sharer beat per cycle while the response register is free, set
// by the list walker that clears the lowest sharer on each beat. Response
// back-pressure stalls both; a new request is taken only when idle.
// Reset: synchronous; clears the entry and loads the configuration defaults.
// ----------------------------------------------------------------------------
// coherence_directory_entry_broadcast
// One limited directory entry with broadcast fallback, built as a sequencing
// controller and a datapath.
// ----------------------------------------------------------------------------
module coherence_directory_entry_broadcast #(
   parameter int TILES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  cdeb_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output cdeb_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cdeb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [6:0]                     csr_data
);
   import cdeb_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   cdeb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   cdeb_datapath #(
      .TILES (TILES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
